// File: rtl/core/hsvh_pkg.sv
package hsvh_pkg;
  localparam int NumBins = 162;
  localparam int BinW = 8;
  localparam int CountWidthDefault = 24;
  localparam int OutCountW = 24;
  localparam int ChanW = 8;
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] read_bin;
  } pix_t;

  typedef struct packed {
    logic [7:0]  bin_index;
    logic [4:0]  hue_bin;
    logic [1:0]  sat_bin;
    logic [1:0]  val_bin;
    logic [23:0] bin_count;
  } res_t;
endpackage

// File: rtl/core/hsvh_if.sv
interface hsvh_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/hsv_color_histogram_core.sv
// a pixel result passes through the one-step-a-cycle hue divider (one step per hue sector),
// then the memory read and write back states before it is presented
// a read command result goes straight to the memory read and write back states
// one transaction in flight; the next is taken once the result is accepted and the core is idle
// reset is synchronous; a clearing pass over all 162 bins zeroes the histogram memory,
// input is not accepted during it
module hsv_color_histogram_core #(
  parameter int CountWidth = hsvh_pkg::CountWidthDefault
) (
  input logic clk,
  input logic rst,
  hsvh_if.sink   in_ch,
  hsvh_if.source out_ch
);
  import hsvh_pkg::*;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_CLASS, ST_READ, ST_WRITE, ST_OUT} st_t;
  st_t st;

  localparam logic [CountWidth-1:0] CMax = '1;

  logic [BinW-1:0] addr, clr_addr;
  logic            cmd;
  logic            cls_done;
  logic [4:0]      hb;
  logic [1:0]      sb, vb;
  logic            we;
  logic [BinW-1:0] waddr, raddr;
  logic [CountWidth-1:0] wdata, rdata;
  logic            valid_bin;
  res_t            res;

  hsvh_classify u_cls (
    .clk, .rst, .start(st == ST_IDLE && in_ch.valid),
    .red(in_ch.data.red), .green(in_ch.data.green), .blue(in_ch.data.blue),
    .done(cls_done), .hue_bin(hb), .sat_bin(sb), .val_bin(vb)
  );

  hsvh_ram #(.Width(CountWidth), .Depth(NumBins)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign raddr = addr;
  assign in_ch.ready = (st == ST_IDLE);
  assign out_ch.valid = (st == ST_OUT);
  assign out_ch.data = res;

  // write back: clear pass, increment, or clear after read
  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata = '0;
    unique case (st)
      ST_CLEAR: begin we = 1'b1; waddr = clr_addr; end
      ST_WRITE: begin
        we = (cmd == CmdPixel) || valid_bin;
        wdata = (cmd == CmdPixel) ? ((rdata == CMax) ? rdata : rdata + 1'b1) : '0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (st)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BinW'(NumBins - 1)) st <= ST_IDLE;
        end
        ST_IDLE: if (in_ch.valid) begin
          cmd <= in_ch.data.cmd;
          addr <= in_ch.data.read_bin;
          valid_bin <= in_ch.data.read_bin < BinW'(NumBins);
          st <= (in_ch.data.cmd == CmdPixel) ? ST_CLASS : ST_READ;
        end
        ST_CLASS: if (cls_done) begin
          addr <= BinW'(hb * 9 + sb * 3 + vb);
          res.hue_bin <= hb; res.sat_bin <= sb; res.val_bin <= vb;
          st <= ST_READ;
        end
        ST_READ: st <= ST_WRITE;
        ST_WRITE: begin
          res.bin_index <= addr;
          if (cmd == CmdPixel) begin
            res.bin_count <= OutCountW'((rdata == CMax) ? rdata : rdata + 1'b1);
          end else begin
            res.hue_bin <= '0; res.sat_bin <= '0; res.val_bin <= '0;
            res.bin_count <= valid_bin ? OutCountW'(rdata) : '0;
          end
          st <= ST_OUT;
        end
        ST_OUT: if (out_ch.ready) st <= ST_IDLE;
        default: st <= ST_IDLE;
      endcase
    end
  end

  // no new transaction while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");
  // every pixel result with a nonzero hue bin lands in a real bin
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && res.hue_bin != 5'd0) |-> res.bin_index < BinW'(NumBins))
    else $error("bin out of range");
  // read command reports zero hue and saturation bin fields
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && cmd == CmdRead) |-> (res.hue_bin == 5'd0 && res.sat_bin == 2'd0))
    else $error("read result carries bins");
endmodule

// File: rtl/core/hsvh_ram.sv
module hsvh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/hsvh_classify.sv
module hsvh_classify (
  input  logic                 clk,
  input  logic                 start,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 done,
  output logic [4:0]           hue_bin,
  output logic [1:0]           sat_bin,
  output logic [1:0]           val_bin,
  input  logic                 rst
);
  import hsvh_pkg::*;

  logic [7:0]  v, mn, d;
  logic signed [13:0] num_c;
  logic [12:0] num;
  logic [7:0]  dd;
  logic [4:0]  hq;
  logic [1:0]  vb_c;
  logic        grey;
  logic [1:0]  sb_c;
  logic [17:0] sat_l;
  logic [16:0] sat_r;
  logic [4:0]  step;
  logic        busy;

  // max, min and hue numerator in units of d
  always_comb begin
    logic signed [13:0] t;
    t = '0;
    if (blue > green && blue > red) begin
      v = blue; mn = (red > green) ? green : red;
      t = 14'(3 * ($signed({4'b0, red}) - $signed({4'b0, green})));
      d = v - mn;
      t = t + 14'(12 * {4'b0, d});
    end else if (green > red) begin
      v = green; mn = (red > blue) ? blue : red;
      t = 14'(3 * ($signed({4'b0, blue}) - $signed({4'b0, red})));
      d = v - mn;
      t = t + 14'(6 * {4'b0, d});
    end else begin
      v = red; mn = (green > blue) ? blue : green;
      t = 14'(3 * ($signed({4'b0, green}) - $signed({4'b0, blue})));
      d = v - mn;
    end
    if (t < 0) t = t + 14'(18 * {4'b0, d});
    num_c = t;
  end

  // value third by compare
  assign vb_c = (v >= 8'd170) ? 2'd2 : (v >= 8'd85) ? 2'd1 : 2'd0;

  // saturation third: 1000*d vs k*333*v
  always_comb begin
    sat_l = 18'(1000 * {10'b0, d});
    sat_r = 17'(333 * {9'b0, v});
    if (sat_l >= 18'({sat_r, 1'b0})) sb_c = 2'd2;
    else if (sat_l >= 18'(sat_r)) sb_c = 2'd1;
    else sb_c = 2'd0;
  end

  // hue quotient by repeated compare and subtract, one step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        grey <= (v == 8'd0) || (d == 8'd0);
        num <= num_c[12:0];
        dd <= d;
        hq <= '0;
        val_bin <= vb_c;
        sat_bin <= ((v == 8'd0) || (d == 8'd0)) ? 2'd0 : sb_c;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (grey || num < {5'b0, dd} || step == 5'd17) begin
          hue_bin <= grey ? 5'd0 : hq;
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          num <= num - {5'b0, dd};
          hq <= hq + 5'd1;
          step <= step + 5'd1;
        end
      end
    end
  end
endmodule

// File: tb/sv/hsv_color_histogram_core_tb.sv
module hsv_color_histogram_core_tb;
  import hsvh_pkg::*;

  localparam int CountW = 24;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  logic clk;
  logic rst;

  hsvh_if #(.payload_t(pix_t)) in_ch ();
  hsvh_if #(.payload_t(res_t)) out_ch ();

  hsv_color_histogram_core #(.CountWidth(CountW)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // shadow histogram and queue of expected results
  logic [CountW-1:0] bin_counts [NumBins];
  res_t expected_results [$];
  int error_count;
  bit hold_off;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("hsv_color_histogram_core_tb: errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // classify a pixel into hue, saturation and value bins
  function automatic res_t classify_pixel(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
    res_t res;
    int v, mn, d, num, q;
    res = '0;
    if (b > g && b > r) begin
      v = b; mn = (r > g) ? g : r; d = v - mn;
      num = 3 * (int'(r) - int'(g)) + 12 * d;
    end else if (g > r) begin
      v = g; mn = (r > b) ? b : r; d = v - mn;
      num = 3 * (int'(b) - int'(r)) + 6 * d;
    end else begin
      v = r; mn = (g > b) ? b : g; d = v - mn;
      num = 3 * (int'(g) - int'(b));
    end
    q = v / 85;
    res.val_bin = 2'((q > 2) ? 2 : q);
    if (v != 0 && d != 0) begin
      if (num < 0) num += 18 * d;
      q = num / d;
      res.hue_bin = 5'((q > 17) ? 17 : q);
      q = (1000 * d) / (333 * v);
      res.sat_bin = 2'((q > 2) ? 2 : q);
    end
    res.bin_index = 8'(res.hue_bin * 9 + res.sat_bin * 3 + res.val_bin);
    return res;
  endfunction

  // predict the result of one transaction and update the shadow histogram
  function automatic res_t histogram_update(input pix_t item);
    res_t res;
    if (item.cmd == CmdPixel) begin
      res = classify_pixel(item.red, item.green, item.blue);
      if (bin_counts[res.bin_index] != CountMax) bin_counts[res.bin_index]++;
      res.bin_count = bin_counts[res.bin_index];
    end else begin
      res = '0;
      res.bin_index = item.read_bin;
      if (item.read_bin < NumBins) begin
        res.bin_count = bin_counts[item.read_bin];
        bin_counts[item.read_bin] = '0;
      end
    end
    return res;
  endfunction

  // sender: random gaps between bursts
  int burst_left;
  task automatic send_item(input pix_t item);
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(histogram_update(item));
    in_ch.valid <= 1'b0;
  endtask

  function automatic pix_t pixel(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
    pix_t p;
    p = '0;
    p.cmd = CmdPixel; p.red = r; p.green = g; p.blue = b;
    p.read_bin = 8'($urandom);
    return p;
  endfunction

  function automatic pix_t read_cmd(input logic [7:0] bin);
    pix_t p;
    p = '0;
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    p.cmd = CmdRead;
    p.read_bin = bin;
    return p;
  endfunction

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver: stall pattern plus long hold-off on request
  initial begin
    int phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        hold_cycles++;
      end else if ((phase / 64) % 2 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // check each result against the oldest expectation
  initial begin
    res_t got, want;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result bin", int'(got.bin_index), -1);
        end else begin
          want = expected_results.pop_front();
          if (got.bin_index != want.bin_index)
            report_mismatch("bin_index", int'(got.bin_index), int'(want.bin_index));
          if (got.hue_bin != want.hue_bin)
            report_mismatch("hue_bin", int'(got.hue_bin), int'(want.hue_bin));
          if (got.sat_bin != want.sat_bin)
            report_mismatch("sat_bin", int'(got.sat_bin), int'(want.sat_bin));
          if (got.val_bin != want.val_bin)
            report_mismatch("val_bin", int'(got.val_bin), int'(want.val_bin));
          if (got.bin_count != want.bin_count)
            report_mismatch("bin_count", int'(got.bin_count), int'(want.bin_count));
        end
      end
    end
  end

  // extremes, grey, black, hue wrap and read edge cases
  task automatic test_directed();
    send_item(pixel(8'd0, 8'd0, 8'd0));
    send_item(pixel(8'd255, 8'd255, 8'd255));
    send_item(pixel(8'd128, 8'd128, 8'd128));
    send_item(pixel(8'd255, 8'd0, 8'd0));
    send_item(pixel(8'd0, 8'd255, 8'd0));
    send_item(pixel(8'd0, 8'd0, 8'd255));
    send_item(pixel(8'd255, 8'd0, 8'd1));
    send_item(pixel(8'd255, 8'd255, 8'd0));
    send_item(pixel(8'd0, 8'd255, 8'd255));
    send_item(pixel(8'd255, 8'd0, 8'd255));
    send_item(pixel(8'd84, 8'd85, 8'd170));
    send_item(pixel(8'd170, 8'd171, 8'd0));
    send_item(pixel(8'd100, 8'd67, 8'd100));
    send_item(read_cmd(8'd0));
    send_item(read_cmd(8'd0));
    send_item(read_cmd(8'd161));
    send_item(read_cmd(8'd162));
    send_item(read_cmd(8'd255));
    send_item(read_cmd(8'd27));
  endtask

  // random pixels with reads mixed in
  task automatic test_random(input int n);
    pix_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        p = read_cmd(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 161)));
      end else if ($urandom_range(0, 3) == 0) begin
        p = pixel(8'($urandom_range(0, 3)) * 8'd85, 8'($urandom_range(250, 255)), 8'($urandom));
      end else begin
        p = pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
      send_item(p);
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles = 0;
    hold_off = 1'b1;
    fork
      test_random(12);
      while (hold_cycles < 300) @(posedge clk);
    join_any
    while (hold_cycles < 300) @(posedge clk);
    hold_off = 1'b0;
    wait fork;
    wait_drained();
  endtask

  // one bin hit repeatedly then read out
  task automatic test_repeat_bin();
    res_t hit;
    for (int i = 0; i < 40; i++) send_item(pixel(8'd200, 8'd10, 8'd10));
    wait_drained();
    hit = classify_pixel(8'd200, 8'd10, 8'd10);
    send_item(read_cmd(hit.bin_index));
  endtask

  initial begin
    error_count = 0;
    burst_left = 0;
    hold_off = 1'b0;
    hold_cycles = 0;
    for (int i = 0; i < NumBins; i++) bin_counts[i] = '0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    wait_drained();
    test_repeat_bin();
    test_random(700);
    test_backpressure();
    test_random(650);
    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("hsv_color_histogram_core_tb: clean");
    end else begin
      $display("hsv_color_histogram_core_tb: errors");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/core/hsvh_pkg.sv
rtl/core/hsvh_if.sv
rtl/core/hsvh_ram.sv
rtl/core/hsvh_classify.sv
rtl/core/hsv_color_histogram_core.sv
tb/sv/hsv_color_histogram_core_tb.sv
